### sv/srp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package srp_pkg;

	// field widths
	localparam int RPM_W    = 15;   // signed wheel speed
	localparam int TIME_W   = 32;   // timestamp
	localparam int THR_W    = 14;   // threshold and tolerance
	localparam int DUR_W    = 22;   // ramp duration
	localparam int GEAR_W   = 16;   // gear ratio, q8
	localparam int VEL_W    = 26;   // motor velocity, q8

	// divider and scaling geometry
	localparam int NUM_W     = 37;  // ramp numerator |diff| * elapsed + d/2
	localparam int RAMP_QB   = 15;  // quotient bits of the ramp division
	localparam int CNT_W     = $clog2(RAMP_QB + 1);
	localparam int PROD_W    = NUM_W;
	localparam int VNUM_W    = 30;  // velocity numerator |cmd| * gear + 30
	localparam int VQN_W     = VNUM_W - 2;  // numerator / 4
	localparam int VREC_W    = 29;  // width of the reciprocal of 15
	localparam int VREC_SH   = 32;  // reciprocal scale 2^32
	localparam int QUO_W     = 25;  // velocity quotient

	localparam int VEL_DIV   = 60;
	localparam int VEL_HALF  = VEL_DIV / 2;

	// x / 60 = ((x >> 2) * ceil(2^32 / 15)) >> 32, exact while x >> 2 is below 2^28
	localparam logic [VREC_W-1:0] VEL_RECIP = VREC_W'(286331154);

	// register reset values
	localparam logic [THR_W-1:0]  THR_RST  = THR_W'(500);
	localparam logic [DUR_W-1:0]  DUR_RST  = DUR_W'(500000);
	localparam logic [THR_W-1:0]  TOL_RST  = THR_W'(100);
	localparam logic [GEAR_W-1:0] GEAR_RST = GEAR_W'(256);

	// register indexes
	localparam logic [1:0] REG_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_DURATION  = 2'd1;
	localparam logic [1:0] REG_TOLERANCE = 2'd2;
	localparam logic [1:0] REG_GEAR      = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_ELAPSE,
		ST_RMUL,
		ST_RLOAD,
		ST_RDIV,
		ST_RFIX,
		ST_VMUL,
		ST_VLOAD,
		ST_VDIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic capture;
		logic decide;
		logic elapse;
		logic rmul;
		logic rfix;
		logic vmul;
		logic div_start;
		logic vsum;
		logic vscale;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic ramp;
		logic ended;
		logic div_done;
	} dp_status_t;

endpackage

`default_nettype wire

### sv/srp_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
// Ramp progress only: 15 bits, quotient known below 2^15.
module srp_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [srp_pkg::NUM_W-1:0]     num,
	input  wire logic [srp_pkg::DUR_W-1:0]     den,
	output logic      [srp_pkg::RAMP_QB-1:0]   quo,
	output logic                               done
);

	localparam int DW = srp_pkg::DUR_W;
	localparam int QW = srp_pkg::RAMP_QB;

	logic [DW-1:0]             rem_q;
	logic [DW-1:0]             den_q;
	logic [QW-1:0]             low_q;
	logic [QW-1:0]             quo_q;
	logic [srp_pkg::CNT_W-1:0] cnt_q;
	logic [DW+1:0]             trial;
	logic                      qbit;

	assign trial = {1'b0, rem_q, low_q[QW-1]} - {2'b00, den_q};
	assign qbit  = ~trial[DW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= srp_pkg::CNT_W'(QW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			quo_q <= '0;
			rem_q <= num[srp_pkg::NUM_W-1:QW];
			low_q <= num[QW-1:0];
		end else if (cnt_q != '0) begin
			rem_q <= qbit ? trial[DW-1:0] : {rem_q[DW-2:0], low_q[QW-1]};
			low_q <= {low_q[QW-2:0], 1'b0};
			quo_q <= {quo_q[QW-2:0], qbit};
		end
	end

	assign quo  = quo_q;
	assign done = (cnt_q == '0);

endmodule

`default_nettype wire

### sv/srp_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module srp_dpath (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire srp_pkg::ctrl_cmd_t                 cmd,
	output srp_pkg::dp_status_t                     status,
	input  wire logic        [srp_pkg::THR_W-1:0]   thr,
	input  wire logic        [srp_pkg::DUR_W-1:0]   dur,
	input  wire logic        [srp_pkg::THR_W-1:0]   tol,
	input  wire logic        [srp_pkg::GEAR_W-1:0]  gear,
	input  wire logic signed [srp_pkg::RPM_W-1:0]   desired_rpm,
	input  wire logic        [srp_pkg::TIME_W-1:0]  time_us,
	output logic signed      [srp_pkg::RPM_W-1:0]   commanded_rpm,
	output logic signed      [srp_pkg::VEL_W-1:0]   motor_velocity_q8,
	output logic                                    ramping
);

	localparam int RW  = srp_pkg::RPM_W;
	localparam int PW  = srp_pkg::PROD_W;
	localparam int VRW = srp_pkg::VQN_W + srp_pkg::VREC_W;

	// item and ramp state
	logic signed [RW-1:0]             des_q, cmd_now_q, tgt_q, org_q;
	logic [srp_pkg::TIME_W-1:0]       now_q, begin_q;
	logic                             ramp_q;
	// working registers
	logic [RW-1:0]                    dmag_q;
	logic [srp_pkg::DUR_W-1:0]        elap_q;
	logic                             neg_q;
	logic [PW-1:0]                    prod_q;
	logic [srp_pkg::VQN_W-1:0]        vnum_q;
	logic [srp_pkg::QUO_W-1:0]        vquo_q;
	// output registers
	logic signed [RW-1:0]             out_cmd_q;
	logic signed [srp_pkg::VEL_W-1:0] out_vel_q;
	logic                             out_ramp_q;

	logic [RW-1:0]                    des_mag, cmd_mag;
	logic [RW:0]                      dc_diff, dt_diff, to_diff, dc_mag, dt_mag, to_mag;
	logic                             ramp, retarget;
	logic [srp_pkg::TIME_W-1:0]       elapsed;
	logic [RW-1:0]                    mul_a;
	logic [srp_pkg::DUR_W-1:0]        mul_b;
	logic [PW-1:0]                    div_num;
	logic [srp_pkg::RAMP_QB-1:0]      quo;
	logic [RW:0]                      step, fixed;
	logic [srp_pkg::VNUM_W-1:0]       vsum;
	logic [VRW-1:0]                   vrec;
	logic [srp_pkg::VEL_W-1:0]        vel_mag;

	function automatic logic [RW-1:0] mag15(input logic [RW-1:0] x);
		return x[RW-1] ? (~x + 1'b1) : x;
	endfunction

	function automatic logic [RW:0] mag16(input logic [RW:0] x);
		return x[RW] ? (~x + 1'b1) : x;
	endfunction

	// spin-up and retarget decision
	assign des_mag  = mag15(des_q);
	assign cmd_mag  = mag15(cmd_now_q);
	assign dc_diff  = {des_q[RW-1], des_q} - {cmd_now_q[RW-1], cmd_now_q};
	assign dt_diff  = {des_q[RW-1], des_q} - {tgt_q[RW-1], tgt_q};
	assign dc_mag   = mag16(dc_diff);
	assign dt_mag   = mag16(dt_diff);
	assign ramp     = (des_mag > cmd_mag) && (dc_mag > (RW+1)'(thr)) && (dur != '0);
	assign retarget = dt_mag > (RW+1)'(tol);

	// ramp progress
	assign elapsed  = now_q - begin_q;
	assign to_diff  = {tgt_q[RW-1], tgt_q} - {org_q[RW-1], org_q};
	assign to_mag   = mag16(to_diff);

	// one multiplier for both products
	assign mul_a = cmd.vmul ? cmd_mag : dmag_q;
	assign mul_b = cmd.vmul ? srp_pkg::DUR_W'(gear) : elap_q;

	assign div_num = prod_q + PW'(dur[srp_pkg::DUR_W-1:1]);

	srp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.num      (div_num),
		.den      (dur),
		.quo      (quo),
		.done     (status.div_done)
	);

	assign step    = {1'b0, quo};
	assign fixed   = {org_q[RW-1], org_q} + (neg_q ? (~step + 1'b1) : step);

	// velocity: round half up, divide by 4 with a shift, then by 15 by reciprocal
	assign vsum    = prod_q[srp_pkg::VNUM_W-1:0] + srp_pkg::VNUM_W'(srp_pkg::VEL_HALF);
	assign vrec    = VRW'(vnum_q) * VRW'(srp_pkg::VEL_RECIP);
	assign vel_mag = {1'b0, vquo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_now_q <= '0;
			tgt_q     <= '0;
			org_q     <= '0;
			begin_q   <= '0;
		end else begin
			if (cmd.decide) begin
				if (!ramp) begin
					cmd_now_q <= des_q;
					tgt_q     <= des_q;
					org_q     <= des_q;
					begin_q   <= now_q;
				end else if (retarget) begin
					org_q     <= cmd_now_q;
					tgt_q     <= des_q;
					begin_q   <= now_q;
				end
			end
			if (cmd.elapse && status.ended) begin
				cmd_now_q <= tgt_q;
			end
			if (cmd.rfix) begin
				cmd_now_q <= fixed[RW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			des_q <= desired_rpm;
			now_q <= time_us;
		end
		if (cmd.decide) begin
			ramp_q <= ramp;
		end
		if (cmd.elapse) begin
			elap_q <= elapsed[srp_pkg::DUR_W-1:0];
			dmag_q <= to_mag[RW-1:0];
			neg_q  <= to_diff[RW];
		end
		if (cmd.rmul || cmd.vmul) begin
			prod_q <= PW'(mul_a) * PW'(mul_b);
		end
		if (cmd.vmul) begin
			neg_q <= cmd_now_q[RW-1];
		end
		if (cmd.vsum) begin
			vnum_q <= vsum[srp_pkg::VNUM_W-1:2];
		end
		if (cmd.vscale) begin
			vquo_q <= vrec[VRW-1:srp_pkg::VREC_SH];
		end
		if (cmd.out_load) begin
			out_cmd_q  <= cmd_now_q;
			out_vel_q  <= neg_q ? (~vel_mag + 1'b1) : vel_mag;
			out_ramp_q <= ramp_q;
		end
	end

	assign status.ramp  = ramp;
	assign status.ended = elapsed >= srp_pkg::TIME_W'(dur);

	assign commanded_rpm     = out_cmd_q;
	assign motor_velocity_q8 = out_vel_q;
	assign ramping           = out_ramp_q;

endmodule

`default_nettype wire

### sv/srp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module srp_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	output logic                     out_valid,
	input  wire logic                out_ready,
	input  wire srp_pkg::dp_status_t status,
	output srp_pkg::ctrl_cmd_t       cmd
);

	srp_pkg::state_t state_q, state_d;
	logic            out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= srp_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			srp_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = srp_pkg::ST_DECIDE;
				end
			end
			srp_pkg::ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = status.ramp ? srp_pkg::ST_ELAPSE : srp_pkg::ST_VMUL;
			end
			srp_pkg::ST_ELAPSE: begin
				cmd.elapse = 1'b1;
				state_d    = status.ended ? srp_pkg::ST_VMUL : srp_pkg::ST_RMUL;
			end
			srp_pkg::ST_RMUL: begin
				cmd.rmul = 1'b1;
				state_d  = srp_pkg::ST_RLOAD;
			end
			srp_pkg::ST_RLOAD: begin
				cmd.div_start = 1'b1;
				state_d       = srp_pkg::ST_RDIV;
			end
			srp_pkg::ST_RDIV: begin
				if (status.div_done) begin
					state_d = srp_pkg::ST_RFIX;
				end
			end
			srp_pkg::ST_RFIX: begin
				cmd.rfix = 1'b1;
				state_d  = srp_pkg::ST_VMUL;
			end
			srp_pkg::ST_VMUL: begin
				cmd.vmul = 1'b1;
				state_d  = srp_pkg::ST_VLOAD;
			end
			srp_pkg::ST_VLOAD: begin
				cmd.vsum = 1'b1;
				state_d  = srp_pkg::ST_VDIV;
			end
			srp_pkg::ST_VDIV: begin
				cmd.vscale = 1'b1;
				state_d    = srp_pkg::ST_OUT;
			end
			srp_pkg::ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = srp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = srp_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

### sv/spinup_setpoint_ramp_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake           Payload
// -------   -----------------   ----------------------------------------------
// cfg       APB psel/penable    paddr[3:2] = register, pwdata/prdata 32 bits
// in        in_valid/in_ready   desired_rpm, time_us
// out       out_valid/out_ready commanded_rpm, motor_velocity_q8, ramping
//
// One item at a time; rpm/60 is a shift and a reciprocal multiply. Direct
// path: decide, velocity multiply, load, scale, output; a run-out ramp adds
// elapse, mid-ramp also multiply, 15 one-bit-per-cycle divider steps, fix-up.
// Reset clears the ramp state to zero and loads the register defaults.
// A finished result waits in the output register; the next item can be
// accepted meanwhile, and stalls at its end until that register is free.
module spinup_setpoint_ramp_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic        [3:0]                 paddr,
	input  wire logic        [31:0]                pwdata,
	output logic             [31:0]                prdata,
	output logic                                   pready,
	// requests
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic signed [srp_pkg::RPM_W-1:0]  desired_rpm,
	input  wire logic        [srp_pkg::TIME_W-1:0] time_us,
	// commands
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic signed      [srp_pkg::RPM_W-1:0]  commanded_rpm,
	output logic signed      [srp_pkg::VEL_W-1:0]  motor_velocity_q8,
	output logic                                   ramping
);

	logic [srp_pkg::THR_W-1:0]  thr_q;
	logic [srp_pkg::DUR_W-1:0]  dur_q;
	logic [srp_pkg::THR_W-1:0]  tol_q;
	logic [srp_pkg::GEAR_W-1:0] gear_q;
	logic                       wr_en;
	logic [1:0]                 reg_idx;

	srp_pkg::ctrl_cmd_t  cmd;
	srp_pkg::dp_status_t status;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];

	// register file; byte lanes below word alignment are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= srp_pkg::THR_RST;
			dur_q  <= srp_pkg::DUR_RST;
			tol_q  <= srp_pkg::TOL_RST;
			gear_q <= srp_pkg::GEAR_RST;
		end else if (wr_en) begin
			case (reg_idx)
				srp_pkg::REG_THRESHOLD: thr_q  <= pwdata[srp_pkg::THR_W-1:0];
				srp_pkg::REG_DURATION:  dur_q  <= pwdata[srp_pkg::DUR_W-1:0];
				srp_pkg::REG_TOLERANCE: tol_q  <= pwdata[srp_pkg::THR_W-1:0];
				srp_pkg::REG_GEAR:      gear_q <= pwdata[srp_pkg::GEAR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			srp_pkg::REG_THRESHOLD: prdata = 32'(thr_q);
			srp_pkg::REG_DURATION:  prdata = 32'(dur_q);
			srp_pkg::REG_TOLERANCE: prdata = 32'(tol_q);
			srp_pkg::REG_GEAR:      prdata = 32'(gear_q);
			default:                prdata = '0;
		endcase
	end

	// sequencing
	srp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// ramp state, multiplier, divider and output registers
	// velocity never reaches the 26-bit limits: |16384 * 65535 / 60| < 2^25
	srp_dpath u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.status            (status),
		.thr               (thr_q),
		.dur               (dur_q),
		.tol               (tol_q),
		.gear              (gear_q),
		.desired_rpm       (desired_rpm),
		.time_us           (time_us),
		.commanded_rpm     (commanded_rpm),
		.motor_velocity_q8 (motor_velocity_q8),
		.ramping           (ramping)
	);

endmodule

`default_nettype wire
